@@ rtl/haptic_velocity_estimator_assert.svh @@
// Assertion macros for the haptic velocity estimator checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef HAPTIC_VELOCITY_ESTIMATOR_ASSERT_SVH
`define HAPTIC_VELOCITY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HVE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hve_pkg.sv @@
// Shared types and constants for the haptic velocity estimator.
// No dependencies; all other RTL files but the assert header import it.
package hve_pkg;

    localparam int POS_W       = 24;
    localparam int VEL_W       = 32;
    localparam int FORCE_W     = 24;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_SELECT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_GAIN = 4'd1;

    localparam logic [15:0] DAMPING_GAIN_RESET = 16'd1049;

    // Unit select codes.
    localparam logic [1:0] UNIT_MM = 2'd0;
    localparam logic [1:0] UNIT_CM = 2'd1;
    localparam logic [1:0] UNIT_DM = 2'd2;
    localparam logic [1:0] UNIT_M  = 2'd3;

    // Axis slots inside the datapath: x, remapped y (-z), remapped z (y).
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Filter coefficients: b in Q28, a in Q20.
    localparam logic signed [23:0] COEF_B0   = 24'sd58948;
    localparam logic signed [23:0] COEF_B1   = 24'sd176845;
    localparam logic signed [23:0] COEF_A1   = 24'sd2882326;
    localparam logic signed [23:0] COEF_NA2  = -24'sd2651010;
    localparam logic signed [23:0] COEF_A3   = 24'sd815373;
    localparam logic signed [23:0] VEL_SCALE = 24'sd500;

    // Operand selection of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DIV_EST,
        MUL_DIV_CHK,
        MUL_DAMP_H,
        MUL_DAMP_L,
        MUL_VEL,
        MUL_B0,
        MUL_B1,
        MUL_A1H,
        MUL_A1L,
        MUL_A2H,
        MUL_A2L,
        MUL_A3H,
        MUL_A3L
    } mul_sel_e;

    // What the datapath does with the product of the previous cycle.
    typedef enum logic [3:0] {
        POST_NONE,
        POST_Q0_LOAD,
        POST_DIV_FIX,
        POST_ACC_LOAD,
        POST_ACC_LOAD20,
        POST_ACC_ADD,
        POST_ACC_ADD20,
        POST_V_LOAD,
        POST_DAMP_DONE,
        POST_FILT_DONE
    } post_e;

    typedef struct packed {
        logic       capture;
        logic       out_load;
        mul_sel_e   mul_sel;
        post_e      post;
        logic [1:0] axis;
    } hve_cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   raw_x;
        logic signed [POS_W-1:0]   raw_y;
        logic signed [POS_W-1:0]   raw_z;
        logic signed [FORCE_W-1:0] cmd_force_x;
        logic signed [FORCE_W-1:0] cmd_force_y;
        logic signed [FORCE_W-1:0] cmd_force_z;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [VEL_W-1:0]   vel_x;
        logic signed [VEL_W-1:0]   vel_y;
        logic signed [VEL_W-1:0]   vel_z;
        logic signed [FORCE_W-1:0] drive_0;
        logic signed [FORCE_W-1:0] drive_1;
        logic signed [FORCE_W-1:0] drive_2;
    } result_t;

    // Unit ratio divisor.
    function automatic logic [9:0] unit_ratio(input logic [1:0] sel);
        logic [9:0] r;
        unique case (sel)
            UNIT_MM: r = 10'd1;
            UNIT_CM: r = 10'd10;
            UNIT_DM: r = 10'd100;
            UNIT_M:  r = 10'd1000;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

    // Reciprocal floor(2^s / r), kept below 2^23.
    function automatic logic [22:0] unit_recip(input logic [1:0] sel);
        logic [22:0] m;
        unique case (sel)
            UNIT_MM: m = 23'd1;
            UNIT_CM: m = 23'd3355443;
            UNIT_DM: m = 23'd2684354;
            UNIT_M:  m = 23'd4294967;
            default: m = 23'd1;
        endcase
        return m;
    endfunction

    // Shift s that goes with the reciprocal.
    function automatic logic [5:0] unit_shift(input logic [1:0] sel);
        logic [5:0] s;
        unique case (sel)
            UNIT_MM: s = 6'd0;
            UNIT_CM: s = 6'd25;
            UNIT_DM: s = 6'd28;
            UNIT_M:  s = 6'd32;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/hve_if.sv @@
// Channel interfaces of the haptic velocity estimator: sample, result, config.
// Depends on hve_pkg for field widths.
interface hve_sample_if;
    import hve_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   raw_x;
    logic signed [POS_W-1:0]   raw_y;
    logic signed [POS_W-1:0]   raw_z;
    logic signed [FORCE_W-1:0] cmd_force_x;
    logic signed [FORCE_W-1:0] cmd_force_y;
    logic signed [FORCE_W-1:0] cmd_force_z;

    modport source (output valid, raw_x, raw_y, raw_z, cmd_force_x, cmd_force_y,
                    cmd_force_z, input ready);
    modport sink (input valid, raw_x, raw_y, raw_z, cmd_force_x, cmd_force_y,
                  cmd_force_z, output ready);
endinterface

interface hve_result_if;
    import hve_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [VEL_W-1:0]   vel_z;
    logic signed [FORCE_W-1:0] drive_0;
    logic signed [FORCE_W-1:0] drive_1;
    logic signed [FORCE_W-1:0] drive_2;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    drive_0, drive_1, drive_2, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  drive_0, drive_1, drive_2, output ready);
endinterface

interface hve_cfg_if;
    import hve_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/hve_controller.sv @@
// Sequencer of the haptic velocity estimator: handshakes and per-axis microsteps.
// Depends on hve_pkg for the command struct and the operation enums.
module hve_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output hve_pkg::hve_cmd_t cmd
);
    import hve_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } state_e;

    // One entry per microstep of an axis; the product of a step is consumed
    // by the post operation of the step after it.
    typedef enum logic [4:0] {
        ST_DIV_EST,
        ST_DAMP_H,
        ST_DIV_CHK,
        ST_DAMP_L,
        ST_VEL,
        ST_V_LOAD,
        ST_DAMP_DONE,
        ST_B0,
        ST_B1,
        ST_A1H,
        ST_A1L,
        ST_A2H,
        ST_A2L,
        ST_A3H,
        ST_A3L,
        ST_ACC_LAST,
        ST_FILT_DONE
    } step_e;

    state_e     state_reg, state_next;
    step_e      step_reg, step_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd.capture  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.post     = POST_NONE;
        cmd.axis     = axis_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RUN;
                    step_next   = ST_DIV_EST;
                    axis_next   = AXIS_X;
                end
            end
            S_RUN:
            begin
                unique case (step_reg)
                    ST_DIV_EST:   begin cmd.mul_sel = MUL_DIV_EST; end
                    ST_DAMP_H:    begin cmd.mul_sel = MUL_DAMP_H;  cmd.post = POST_Q0_LOAD;    end
                    ST_DIV_CHK:   begin cmd.mul_sel = MUL_DIV_CHK; cmd.post = POST_ACC_LOAD20; end
                    ST_DAMP_L:    begin cmd.mul_sel = MUL_DAMP_L;  cmd.post = POST_DIV_FIX;    end
                    ST_VEL:       begin cmd.mul_sel = MUL_VEL;     cmd.post = POST_ACC_ADD;    end
                    ST_V_LOAD:    begin cmd.post = POST_V_LOAD;    end
                    ST_DAMP_DONE: begin cmd.post = POST_DAMP_DONE; end
                    ST_B0:        begin cmd.mul_sel = MUL_B0;  end
                    ST_B1:        begin cmd.mul_sel = MUL_B1;  cmd.post = POST_ACC_LOAD;  end
                    ST_A1H:       begin cmd.mul_sel = MUL_A1H; cmd.post = POST_ACC_ADD;   end
                    ST_A1L:       begin cmd.mul_sel = MUL_A1L; cmd.post = POST_ACC_ADD20; end
                    ST_A2H:       begin cmd.mul_sel = MUL_A2H; cmd.post = POST_ACC_ADD;   end
                    ST_A2L:       begin cmd.mul_sel = MUL_A2L; cmd.post = POST_ACC_ADD20; end
                    ST_A3H:       begin cmd.mul_sel = MUL_A3H; cmd.post = POST_ACC_ADD;   end
                    ST_A3L:       begin cmd.mul_sel = MUL_A3L; cmd.post = POST_ACC_ADD20; end
                    ST_ACC_LAST:  begin cmd.post = POST_ACC_ADD;   end
                    ST_FILT_DONE: begin cmd.post = POST_FILT_DONE; end
                    default:      begin cmd.post = POST_NONE;      end
                endcase

                if (step_reg == ST_FILT_DONE)
                begin
                    step_next = ST_DIV_EST;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_e'(step_reg + 5'd1);
                end
            end
            S_FINISH:
            begin
                // The output register is free when empty or being taken now.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_DIV_EST;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/hve_datapath.sv @@
// Datapath of the haptic velocity estimator: shared multiplier, accumulator,
// histories and result register. Depends on hve_pkg; driven by hve_controller.
module hve_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hve_pkg::hve_cmd_t                   cmd,
    input  hve_pkg::sample_t                    sample_data,
    input  logic                                cfg_we,
    input  logic [hve_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hve_pkg::CFG_DATA_W-1:0]      cfg_data,
    output hve_pkg::result_t                    result_data
);
    import hve_pkg::*;

    function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
        logic signed [23:0] r;
        if (v > 38'sd8388607)
            r = 24'sd8388607;
        else if (v < -38'sd8388608)
            r = -24'sd8388608;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
        logic signed [39:0] r;
        if (v > 44'sd549755813887)
            r = 40'sd549755813887;
        else if (v < -44'sd549755813888)
            r = -40'sd549755813888;
        else
            r = v[39:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'sd2147483647;
        else if (v < -33'sd2147483648)
            r = -32'sd2147483648;
        else
            r = v[31:0];
        return r;
    endfunction

    // Configuration registers.
    logic [1:0]  unit_sel_reg;
    logic [15:0] damp_gain_reg;

    // Histories, cleared by reset.
    logic signed [23:0] ph_reg [0:2][0:1];
    logic signed [31:0] vh_reg [0:2][0:2];
    logic signed [39:0] yh_reg [0:2][0:2];

    // Working registers.
    logic signed [23:0] raw_reg    [0:2];
    logic signed [23:0] cmdf_reg   [0:2];
    logic signed [23:0] pos_reg    [0:2];
    logic signed [31:0] vel_reg    [0:2];
    logic signed [36:0] damped_reg [0:2];
    logic signed [31:0] v_reg;
    logic [23:0]        q0_reg;
    logic signed [63:0] acc_reg;
    logic signed [56:0] prod_reg;
    result_t            res_reg;

    logic [1:0]         ax;
    logic signed [23:0] x_sel;
    logic [23:0]        x_bits, x_mag;
    logic               x_neg;
    logic [9:0]         ratio;
    logic [22:0]        recip;
    logic [5:0]         div_shift;
    logic [56:0]        q0_full;
    logic [25:0]        rem;
    logic [23:0]        q_fix;
    logic signed [24:0] pos_signed;
    logic signed [23:0] pos_new;
    logic signed [27:0] p28, p1_28, p2_28, d_sum;
    logic signed [39:0] y0, y1, y2;
    logic signed [32:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [63:0] prod64, prod_sh20, acc_rnd;
    logic signed [56:0] v_trunc;
    logic signed [36:0] damp37;
    logic signed [39:0] y_new;
    logic signed [40:0] vel_rnd;
    logic signed [31:0] vel_new;

    assign ax        = cmd.axis;
    assign x_sel     = raw_reg[ax];
    assign x_bits    = x_sel;
    assign x_neg     = x_sel[23];
    assign x_mag     = x_neg ? (~x_bits + 24'd1) : x_bits;
    assign ratio     = unit_ratio(unit_sel_reg);
    assign recip     = unit_recip(unit_sel_reg);
    assign div_shift = unit_shift(unit_sel_reg);

    // Quotient estimate is exact or one low; a remainder check fixes it.
    assign q0_full    = $unsigned(prod_reg) >> div_shift;
    assign rem        = {2'b00, x_mag} - prod_reg[25:0];
    assign q_fix      = (rem >= {16'd0, ratio}) ? (q0_reg + 24'd1) : q0_reg;
    assign pos_signed = (x_neg ^ (ax == AXIS_Y)) ? -$signed({1'b0, q_fix})
                                                 : $signed({1'b0, q_fix});
    assign pos_new    = sat24(38'(pos_signed));

    // Second-order backward difference numerator.
    assign p28   = 28'(pos_reg[ax]);
    assign p1_28 = 28'(ph_reg[ax][0]);
    assign p2_28 = 28'(ph_reg[ax][1]);
    assign d_sum = (p28 <<< 1) + p28 - (p1_28 <<< 2) + p2_28;

    assign y0 = yh_reg[ax][0];
    assign y1 = yh_reg[ax][1];
    assign y2 = yh_reg[ax][2];

    // 40-bit filter states are fed as a signed upper half and an unsigned
    // lower half of 20 bits each.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_NONE:    begin mul_a = '0; mul_b = '0; end
            MUL_DIV_EST: begin mul_a = {9'd0, x_mag};  mul_b = {1'b0, recip}; end
            MUL_DIV_CHK: begin mul_a = {9'd0, q0_reg}; mul_b = {14'd0, ratio}; end
            MUL_DAMP_H:  begin mul_a = 33'($signed(y0[39:20])); mul_b = {8'd0, damp_gain_reg}; end
            MUL_DAMP_L:  begin mul_a = {13'd0, y0[19:0]};       mul_b = {8'd0, damp_gain_reg}; end
            MUL_VEL:     begin mul_a = 33'(d_sum); mul_b = VEL_SCALE; end
            MUL_B0:      begin mul_a = 33'(v_reg) + 33'(vh_reg[ax][2]);         mul_b = COEF_B0; end
            MUL_B1:      begin mul_a = 33'(vh_reg[ax][0]) + 33'(vh_reg[ax][1]); mul_b = COEF_B1; end
            MUL_A1H:     begin mul_a = 33'($signed(y0[39:20])); mul_b = COEF_A1;  end
            MUL_A1L:     begin mul_a = {13'd0, y0[19:0]};       mul_b = COEF_A1;  end
            MUL_A2H:     begin mul_a = 33'($signed(y1[39:20])); mul_b = COEF_NA2; end
            MUL_A2L:     begin mul_a = {13'd0, y1[19:0]};       mul_b = COEF_NA2; end
            MUL_A3H:     begin mul_a = 33'($signed(y2[39:20])); mul_b = COEF_A3;  end
            MUL_A3L:     begin mul_a = {13'd0, y2[19:0]};       mul_b = COEF_A3;  end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod64    = 64'(prod_reg);
    assign prod_sh20 = prod64 <<< 20;
    assign acc_rnd   = acc_reg + 64'sd524288;
    assign damp37    = acc_rnd[56:20];
    // Division by 16 truncating toward zero.
    assign v_trunc   = prod_reg[56] ? ((prod_reg + 57'sd15) >>> 4) : (prod_reg >>> 4);
    assign y_new     = sat40(acc_rnd[63:20]);
    assign vel_rnd   = 41'(y_new) + 41'sd128;
    assign vel_new   = sat32(vel_rnd[40:8]);

    // Configuration and history state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_sel_reg  <= UNIT_MM;
            damp_gain_reg <= DAMPING_GAIN_RESET;
            for (int a = 0; a < 3; a++)
            begin
                ph_reg[a][0] <= '0;
                ph_reg[a][1] <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    vh_reg[a][k] <= '0;
                    yh_reg[a][k] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_UNIT_SELECT))
                unit_sel_reg <= cfg_data[1:0];
            if (cfg_we && (cfg_index == REG_DAMPING_GAIN))
                damp_gain_reg <= cfg_data[15:0];
            if (cmd.post == POST_FILT_DONE)
            begin
                ph_reg[ax][1] <= ph_reg[ax][0];
                ph_reg[ax][0] <= pos_reg[ax];
                vh_reg[ax][2] <= vh_reg[ax][1];
                vh_reg[ax][1] <= vh_reg[ax][0];
                vh_reg[ax][0] <= v_reg;
                yh_reg[ax][2] <= yh_reg[ax][1];
                yh_reg[ax][1] <= yh_reg[ax][0];
                yh_reg[ax][0] <= y_new;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.capture)
        begin
            raw_reg[AXIS_X]  <= sample_data.raw_x;
            raw_reg[AXIS_Y]  <= sample_data.raw_z;
            raw_reg[AXIS_Z]  <= sample_data.raw_y;
            cmdf_reg[AXIS_X] <= sample_data.cmd_force_x;
            cmdf_reg[AXIS_Y] <= sample_data.cmd_force_y;
            cmdf_reg[AXIS_Z] <= sample_data.cmd_force_z;
        end

        unique case (cmd.post)
            POST_NONE:       begin end
            POST_Q0_LOAD:    q0_reg <= q0_full[23:0];
            POST_DIV_FIX:    pos_reg[ax] <= pos_new;
            POST_ACC_LOAD:   acc_reg <= prod64;
            POST_ACC_LOAD20: acc_reg <= prod_sh20;
            POST_ACC_ADD:    acc_reg <= acc_reg + prod64;
            POST_ACC_ADD20:  acc_reg <= acc_reg + prod_sh20;
            POST_V_LOAD:     v_reg <= v_trunc[31:0];
            POST_DAMP_DONE:  damped_reg[ax] <= 37'(cmdf_reg[ax]) - damp37;
            POST_FILT_DONE:  vel_reg[ax] <= vel_new;
            default:         begin end
        endcase

        if (cmd.out_load)
        begin
            res_reg.pos_x   <= pos_reg[AXIS_X];
            res_reg.pos_y   <= pos_reg[AXIS_Y];
            res_reg.pos_z   <= pos_reg[AXIS_Z];
            res_reg.vel_x   <= vel_reg[AXIS_X];
            res_reg.vel_y   <= vel_reg[AXIS_Y];
            res_reg.vel_z   <= vel_reg[AXIS_Z];
            res_reg.drive_0 <= sat24(38'(damped_reg[AXIS_X]));
            res_reg.drive_1 <= sat24(38'(damped_reg[AXIS_Z]));
            res_reg.drive_2 <= sat24(-38'(damped_reg[AXIS_Y]));
        end
    end

    assign result_data = res_reg;

endmodule

@@ rtl/haptic_velocity_estimator.sv @@
// Top level of the haptic velocity estimator.
// Depends on hve_pkg, the channel interfaces, hve_controller and hve_datapath.
//
// Usage: one servo sample per transfer on the sample channel (raw stylus
// translation and commanded force) gives exactly one transfer on the result
// channel: scaled position, filtered velocity and damped drive force.
// The cfg channel writes unit_select (index 0) and damping_gain (index 1);
// its ready is always high and other indexes are dropped. Write it only
// while no sample is in flight.
// Flow: a sample transfer captures the sample; then each of the three axes
// takes 17 steps on the single shared 33x24 multiplier, and a last step
// loads the output register once that register is free. One sample is in
// work at a time and the sample channel reopens in the cycle after the
// load, so a new sample is accepted only once the previous one is loaded.
// A finished result waits in its own output register, so the next sample
// is accepted while the previous result is still waiting. When the
// receiver stalls, a finished sample holds until the register frees.
// Reset clears all histories and sets unit_select to 0 and damping_gain
// to 1049; the block is ready for a sample in the first cycle after reset.
module haptic_velocity_estimator (
    input  logic         clk,
    input  logic         rst_n,
    hve_sample_if.sink   sample,
    hve_result_if.source result,
    hve_cfg_if.sink      cfg
);
    import hve_pkg::*;

    hve_cmd_t cmd;
    sample_t  sample_data;
    result_t  result_data;

    // Registers can always be written.
    assign cfg.ready = 1'b1;

    assign sample_data.raw_x       = sample.raw_x;
    assign sample_data.raw_y       = sample.raw_y;
    assign sample_data.raw_z       = sample.raw_z;
    assign sample_data.cmd_force_x = sample.cmd_force_x;
    assign sample_data.cmd_force_y = sample.cmd_force_y;
    assign sample_data.cmd_force_z = sample.cmd_force_z;

    hve_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .out_ready (result.ready),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    hve_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_data (sample_data),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result_data (result_data)
    );

    assign result.pos_x   = result_data.pos_x;
    assign result.pos_y   = result_data.pos_y;
    assign result.pos_z   = result_data.pos_z;
    assign result.vel_x   = result_data.vel_x;
    assign result.vel_y   = result_data.vel_y;
    assign result.vel_z   = result_data.vel_z;
    assign result.drive_0 = result_data.drive_0;
    assign result.drive_1 = result_data.drive_1;
    assign result.drive_2 = result_data.drive_2;

endmodule

@@ rtl/hve_checker.sv @@
// Port-level checker for the haptic velocity estimator, bound to the top level.
// Depends on hve_pkg and haptic_velocity_estimator_assert.svh.
`include "haptic_velocity_estimator_assert.svh"

module hve_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [hve_pkg::POS_W-1:0]   out_pos_x,
    input logic signed [hve_pkg::VEL_W-1:0]   out_vel_x
);
    import hve_pkg::*;

    // A stalled result keeps its valid, its pos_x and its vel_x.
    `HVE_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(out_vel_x), "result changed while stalled")

    // Only one sample is in work at a time.
    `HVE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "sample accepted while busy")

    // A new result never appears right after a sample transfer.
    `HVE_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid, "result too early")

    // A result is only produced while a sample was in work.
    `HVE_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready), "result without work")

endmodule

bind haptic_velocity_estimator hve_checker u_hve_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_pos_x (result.pos_x),
    .out_vel_x (result.vel_x)
);

@@ tb/sv/hve_servo_checker.sv @@
// Result checker for the haptic velocity estimator: it watches the sample, cfg and
// result channels, predicts each servo result on its own and compares it field by field.
// Depends on hve_pkg and on the channel interfaces of hve_if.sv.
module hve_servo_checker
    import hve_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    hve_sample_if sample,
    hve_result_if result,
    hve_cfg_if    cfg,
    output int    mismatch_count,
    output int    outputs_checked,
    output int    outputs_pending
);

    // Filter taps: b in Q28, a in Q20; difference gain is 1 / (2 * 0.002 s) times 2.
    localparam longint TAP_B0    = 58948;
    localparam longint TAP_B1    = 176845;
    localparam longint TAP_A1    = 2882326;
    localparam longint TAP_A2    = 2651010;
    localparam longint TAP_A3    = 815373;
    localparam longint DIFF_GAIN = 500;
    localparam int     FILT_W    = 40;
    localparam int     NUM_FIELDS = 9;

    logic [1:0] unit_now;
    longint     damping_now;
    longint     pos_hist [3][2];
    longint     rawvel_hist [3][3];
    longint     filt_hist [3][3];
    result_t    expected_outputs [$];
    string      field_names [NUM_FIELDS] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y",
                                             "vel_z", "drive_0", "drive_1", "drive_2"};

    function automatic longint saturate(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Round half up, then floor: add half an LSB and shift arithmetically.
    function automatic longint shift_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint field_value(result_t r, int i);
        case (i)
            0:       return longint'($signed(r.pos_x));
            1:       return longint'($signed(r.pos_y));
            2:       return longint'($signed(r.pos_z));
            3:       return longint'($signed(r.vel_x));
            4:       return longint'($signed(r.vel_y));
            5:       return longint'($signed(r.vel_z));
            6:       return longint'($signed(r.drive_0));
            7:       return longint'($signed(r.drive_1));
            default: return longint'($signed(r.drive_2));
        endcase
    endfunction

    // Works out the result of one servo sample and advances the histories.
    function automatic result_t predict_servo_output(sample_t s);
        longint  ratio;
        longint  cmd [3];
        longint  pos [3];
        longint  damped [3];
        longint  vel [3];
        longint  v;
        longint  acc;
        longint  y;
        int      a;
        result_t r;
        case (unit_now)
            UNIT_MM: ratio = 1;
            UNIT_CM: ratio = 10;
            UNIT_DM: ratio = 100;
            default: ratio = 1000;
        endcase
        cmd[0] = longint'($signed(s.cmd_force_x));
        cmd[1] = longint'($signed(s.cmd_force_y));
        cmd[2] = longint'($signed(s.cmd_force_z));
        // Axes are remapped to (x, -z, y); division truncates toward zero.
        pos[0] = saturate(longint'($signed(s.raw_x)) / ratio, POS_W);
        pos[1] = saturate(-(longint'($signed(s.raw_z)) / ratio), POS_W);
        pos[2] = saturate(longint'($signed(s.raw_y)) / ratio, POS_W);
        for (a = 0; a < 3; a++) begin
            // Damping acts on the filtered velocity of the previous sample.
            damped[a] = cmd[a] - shift_round(damping_now * filt_hist[a][0], 20);
            v = (DIFF_GAIN * (3 * pos[a] - 4 * pos_hist[a][0] + pos_hist[a][1])) / 16;
            acc = TAP_B0 * (v + rawvel_hist[a][2])
                + TAP_B1 * (rawvel_hist[a][0] + rawvel_hist[a][1])
                + TAP_A1 * filt_hist[a][0]
                - TAP_A2 * filt_hist[a][1]
                + TAP_A3 * filt_hist[a][2];
            y = saturate(shift_round(acc, 20), FILT_W);
            pos_hist[a][1]    = pos_hist[a][0];
            pos_hist[a][0]    = pos[a];
            rawvel_hist[a][2] = rawvel_hist[a][1];
            rawvel_hist[a][1] = rawvel_hist[a][0];
            rawvel_hist[a][0] = v;
            filt_hist[a][2]   = filt_hist[a][1];
            filt_hist[a][1]   = filt_hist[a][0];
            filt_hist[a][0]   = y;
            vel[a] = saturate(shift_round(y, 8), VEL_W);
        end
        r.pos_x   = POS_W'(pos[0]);
        r.pos_y   = POS_W'(pos[1]);
        r.pos_z   = POS_W'(pos[2]);
        r.vel_x   = VEL_W'(vel[0]);
        r.vel_y   = VEL_W'(vel[1]);
        r.vel_z   = VEL_W'(vel[2]);
        r.drive_0 = FORCE_W'(saturate(damped[0], FORCE_W));
        r.drive_1 = FORCE_W'(saturate(damped[2], FORCE_W));
        r.drive_2 = FORCE_W'(saturate(-damped[1], FORCE_W));
        return r;
    endfunction

    // Channels are sampled at the falling edge: a transfer seen here takes
    // place at the next rising edge, and nothing moves in between.
    always @(negedge clk) begin : watch
        result_t seen;
        result_t want;
        sample_t s;
        int      i;
        int      a;
        if (!rst_n) begin
            unit_now    = UNIT_MM;
            damping_now = longint'(DAMPING_GAIN_RESET);
            for (a = 0; a < 3; a++) begin
                pos_hist[a]    = '{0, 0};
                rawvel_hist[a] = '{0, 0, 0};
                filt_hist[a]   = '{0, 0, 0};
            end
            expected_outputs.delete();
            mismatch_count  = 0;
            outputs_checked = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_UNIT_SELECT:  unit_now = cfg.data[1:0];
                    REG_DAMPING_GAIN: damping_now = longint'(cfg.data);
                    default:          ;
                endcase
            end
            // Results are checked before new samples are queued, so a result
            // can never be matched against the sample that arrives beside it.
            if (result.valid && result.ready) begin
                seen.pos_x   = result.pos_x;
                seen.pos_y   = result.pos_y;
                seen.pos_z   = result.pos_z;
                seen.vel_x   = result.vel_x;
                seen.vel_y   = result.vel_y;
                seen.vel_z   = result.vel_z;
                seen.drive_0 = result.drive_0;
                seen.drive_1 = result.drive_1;
                seen.drive_2 = result.drive_2;
                if (expected_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result transfer with no sample waiting for it");
                end else begin
                    want = expected_outputs.pop_front();
                    for (i = 0; i < NUM_FIELDS; i++) begin
                        if (field_value(want, i) != field_value(seen, i)) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("Result %0d, %s: expected %0d, got %0d",
                                         outputs_checked, field_names[i],
                                         field_value(want, i), field_value(seen, i));
                        end
                    end
                    outputs_checked++;
                end
            end
            if (sample.valid && sample.ready) begin
                s.raw_x       = sample.raw_x;
                s.raw_y       = sample.raw_y;
                s.raw_z       = sample.raw_z;
                s.cmd_force_x = sample.cmd_force_x;
                s.cmd_force_y = sample.cmd_force_y;
                s.cmd_force_z = sample.cmd_force_z;
                expected_outputs.push_back(predict_servo_output(s));
            end
        end
        outputs_pending = expected_outputs.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the haptic velocity estimator testbench: clock, reset, sample and
// register stimulus, result-side flow control and the final verdict.
// Depends on hve_pkg, hve_if.sv, the block itself and hve_servo_checker.
module tb_top;
    import hve_pkg::*;

    // The limit is several times the slowest expected run with both sides
    // stalling as hard as they do here.
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     SEGMENTS      = 12;
    localparam int     SEGMENT_ITEMS = 57;
    localparam int     SETTLE_CYCLES = 60;
    localparam longint POS_MAX       = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN       = -POS_MAX - 1;
    localparam logic [1:0] UNIT_ORDER [4] = '{UNIT_MM, UNIT_CM, UNIT_DM, UNIT_M};

    logic clk;
    logic rst_n;

    // Flow control in percent: how often the sender holds back a sample and
    // how often the receiver refuses a result. Start with a slow receiver.
    int src_idle_pct  = 34;
    int rcv_stall_pct = 88;

    int cycle_count = 0;
    int samples_sent = 0;
    int settings_used = 0;
    int mismatch_count;
    int outputs_checked;
    int outputs_pending;

    hve_sample_if sample_ch ();
    hve_result_if result_ch ();
    hve_cfg_if    cfg_ch ();

    haptic_velocity_estimator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    hve_servo_checker servo_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .mismatch_count  (mismatch_count),
        .outputs_checked (outputs_checked),
        .outputs_pending (outputs_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d results still outstanding",
                     outputs_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: ready is redrawn every cycle, so stalls land on every
    // phase of the block's work, including while the next sample is busy.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic sample_t make_sample(longint rx, longint ry, longint rz,
                                            longint fx, longint fy, longint fz);
        sample_t s;
        s.raw_x       = POS_W'(rx);
        s.raw_y       = POS_W'(ry);
        s.raw_z       = POS_W'(rz);
        s.cmd_force_x = FORCE_W'(fx);
        s.cmd_force_y = FORCE_W'(fy);
        s.cmd_force_z = FORCE_W'(fz);
        return s;
    endfunction

    // The field extremes plus the values right around zero.
    function automatic longint pick_extreme();
        case ($urandom_range(4))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // Offers one sample after a random number of idle cycles and returns at
    // the rising edge of its transfer. Valid stays high on return so that a
    // following sample can go out without a gap; idling lowers it.
    task automatic send_sample(input sample_t s);
        logic fire;
        while ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.raw_x       <= s.raw_x;
        sample_ch.raw_y       <= s.raw_y;
        sample_ch.raw_z       <= s.raw_z;
        sample_ch.cmd_force_x <= s.cmd_force_x;
        sample_ch.cmd_force_y <= s.cmd_force_y;
        sample_ch.cmd_force_z <= s.cmd_force_z;
        do begin
            @(negedge clk);
            fire = sample_ch.ready;
            @(posedge clk);
        end while (!fire);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        logic fire;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do begin
            @(negedge clk);
            fire = cfg_ch.ready;
            @(posedge clk);
        end while (!fire);
    endtask

    // Writes both registers and one unused index. The unit code carries random
    // upper bits, which the block must mask off; the stray write must be dropped.
    task automatic program_regs(input logic [1:0] unit, input logic [15:0] gain);
        write_reg(REG_UNIT_SELECT, {14'($urandom), unit});
        write_reg(REG_DAMPING_GAIN, gain);
        write_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, REG_DAMPING_GAIN + 1)),
                  CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Stops offering samples and waits for every predicted result, so the
    // block is idle and registers may be written.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (outputs_pending != 0)
            @(posedge clk);
    endtask

    initial begin : stimulus
        longint     walk [3];
        longint     p;
        int         seg;
        int         n;
        int         a;
        int         kind;
        int         span;
        logic [15:0] gain;

        // Reset is asserted asynchronously from the start and released once.
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.raw_x       <= '0;
        sample_ch.raw_y       <= '0;
        sample_ch.raw_z       <= '0;
        sample_ch.cmd_force_x <= '0;
        sample_ch.cmd_force_y <= '0;
        sample_ch.cmd_force_z <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_UNIT_SELECT;
        cfg_ch.data           <= '0;
        walk = '{0, 0, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings (millimeters, default damping).
        // The second sample overflows the negated z position and, with no
        // velocity yet, the negated y force on drive_2.
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(POS_MAX, 0, POS_MIN, POS_MAX, POS_MIN, POS_MIN));
        send_sample(make_sample(POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MAX, POS_MAX));
        send_sample(make_sample(POS_MAX, POS_MIN, POS_MIN, 0, 0, 0));
        send_sample(make_sample(-1, 1, -1, -1, 1, -1));

        // Full damping gain with full-scale position swings drives the filter
        // toward its limits and the damped forces into saturation both ways.
        drain_results();
        program_regs(UNIT_MM, 16'hFFFF);
        for (n = 0; n < 10; n++) begin
            p = (n % 2 == 0 || n >= 8) ? POS_MAX : POS_MIN;
            send_sample(make_sample(p, -p - 1, p, p, -p - 1, p));
        end

        // Meters with no damping: quotients truncate toward zero on both signs.
        drain_results();
        program_regs(UNIT_M, 16'h0000);
        send_sample(make_sample(999, -999, 1001, 0, POS_MIN, 0));
        send_sample(make_sample(-1001, 1999, POS_MIN, POS_MAX, POS_MIN, POS_MIN));
        send_sample(make_sample(POS_MAX, POS_MIN, POS_MAX, 0, 0, 0));
        send_sample(make_sample(-1000, 1000, -1, 1, 1, 1));

        // Random part. Every unit code meets zero, full-scale and random
        // damping; the first four segments use a slow receiver, the next four
        // a slow sender and the last four run without any idling.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg % 3)
                0:       gain = 16'($urandom);
                1:       gain = 16'hFFFF;
                default: gain = 16'h0000;
            endcase
            if (seg / 4 == 1) begin
                src_idle_pct  = 88;
                rcv_stall_pct = 34;
            end else if (seg / 4 == 2) begin
                src_idle_pct  = 0;
                rcv_stall_pct = 0;
            end
            program_regs(UNIT_ORDER[seg % 4], gain);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                kind = $urandom_range(99);
                if (kind < 60) begin
                    // A stylus path: steps from tiny to large, kept in range,
                    // so the filter sees realistic, correlated motion.
                    for (a = 0; a < 3; a++) begin
                        span = $urandom_range(18);
                        walk[a] += longint'($urandom_range(2 << span)) - (longint'(1) << span);
                        if (walk[a] > POS_MAX)
                            walk[a] = POS_MAX;
                        if (walk[a] < POS_MIN)
                            walk[a] = POS_MIN;
                    end
                    send_sample(make_sample(walk[0], walk[1], walk[2],
                                            $urandom, $urandom, $urandom));
                end else if (kind < 85) begin
                    send_sample(make_sample($urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom));
                end else begin
                    send_sample(make_sample(pick_extreme(), pick_extreme(), pick_extreme(),
                                            pick_extreme(), pick_extreme(), pick_extreme()));
                end
            end
        end

        // Let every result arrive, then give a stray late result time to show.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d servo samples, checked %0d results under %0d register settings.",
                 samples_sent, outputs_checked, settings_used);
        $display("All four unit codes, damping from zero to full scale, three stall patterns.");
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ haptic_velocity_estimator.f @@
+incdir+rtl
rtl/hve_pkg.sv
rtl/hve_if.sv
rtl/hve_controller.sv
rtl/hve_datapath.sv
rtl/haptic_velocity_estimator.sv
rtl/hve_checker.sv
tb/sv/hve_servo_checker.sv
tb/sv/tb_top.sv
